[rtl/core/pspf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspf_pkg
// Shared constants, result type and grading function of the particle sensor
// frame parser.
// ----------------------------------------------------------------------------
package pspf_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int CAT_W   = 3;
    localparam int POS_W   = 5;
    localparam int NUM_LEVELS = 5;

    localparam logic [BYTE_W-1:0] START_FIRST  = 8'h42;
    localparam logic [BYTE_W-1:0] START_SECOND = 8'h4d;

    typedef logic [WORD_W-1:0] limit_table_t [NUM_LEVELS];

    localparam limit_table_t PM25_LIMITS = '{16'd13, 16'd36, 16'd56, 16'd151, 16'd251};
    localparam limit_table_t PM10_LIMITS = '{16'd55, 16'd155, 16'd255, 16'd355, 16'd425};

    typedef struct packed {
        logic [WORD_W-1:0] pm1_value;
        logic [WORD_W-1:0] pm25_value;
        logic [WORD_W-1:0] pm10_value;
        logic [CAT_W-1:0]  pm25_category;
        logic [CAT_W-1:0]  pm10_category;
        logic [CAT_W-1:0]  worst_category;
    } pspf_result_t;

    // Index of the first limit that the value stays below; all limits
    // exceeded or reached gives the level count.
    function automatic logic [CAT_W-1:0] grade(input logic [WORD_W-1:0] value,
                                               input limit_table_t limits);
        logic [CAT_W-1:0] cat;
        cat = CAT_W'(NUM_LEVELS);
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (value < limits[i]) begin
                cat = CAT_W'(i);
            end
        end
        return cat;
    endfunction

endpackage

[rtl/core/pspf_byte_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspf_byte_if
// Request channel that carries one received serial byte.
// ----------------------------------------------------------------------------
interface pspf_byte_if;
    logic                         valid;
    logic                         ready;
    logic [pspf_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/pspf_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspf_result_if
// Request channel that carries one decoded sensor frame.
// ----------------------------------------------------------------------------
interface pspf_result_if;
    logic                         valid;
    logic                         ready;
    logic [pspf_pkg::WORD_W-1:0]  pm1_value;
    logic [pspf_pkg::WORD_W-1:0]  pm25_value;
    logic [pspf_pkg::WORD_W-1:0]  pm10_value;
    logic [pspf_pkg::CAT_W-1:0]   pm25_category;
    logic [pspf_pkg::CAT_W-1:0]   pm10_category;
    logic [pspf_pkg::CAT_W-1:0]   worst_category;

    modport source (output valid, output pm1_value, output pm25_value, output pm10_value,
                    output pm25_category, output pm10_category, output worst_category,
                    input ready);
    modport sink   (input valid, input pm1_value, input pm25_value, input pm10_value,
                    input pm25_category, input pm10_category, input worst_category,
                    output ready);
endinterface

[rtl/core/pspf_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspf_parser
// Frame position counter, running checksum and held concentration words.
// ----------------------------------------------------------------------------
module pspf_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [pspf_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         hit,
    output pspf_pkg::pspf_result_t       result
);
    import pspf_pkg::*;

    localparam logic [POS_W-1:0] POS_HUNT    = 5'd0;
    localparam logic [POS_W-1:0] POS_SECOND  = 5'd1;
    localparam logic [POS_W-1:0] POS_PM1_HI  = 5'd4;
    localparam logic [POS_W-1:0] POS_PM1_LO  = 5'd5;
    localparam logic [POS_W-1:0] POS_PM25_HI = 5'd6;
    localparam logic [POS_W-1:0] POS_PM25_LO = 5'd7;
    localparam logic [POS_W-1:0] POS_PM10_HI = 5'd8;
    localparam logic [POS_W-1:0] POS_PM10_LO = 5'd9;
    localparam logic [POS_W-1:0] POS_CHK_HI  = 5'd30;
    localparam logic [POS_W-1:0] POS_CHK_LO  = 5'd31;

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [WORD_W-1:0] sum_reg,  sum_next;
    logic [WORD_W-1:0] pm1_reg,  pm1_next;
    logic [WORD_W-1:0] pm25_reg, pm25_next;
    logic [WORD_W-1:0] pm10_reg, pm10_next;
    logic [BYTE_W-1:0] chk_hi_reg, chk_hi_next;
    logic [CAT_W-1:0]  cat25;
    logic [CAT_W-1:0]  cat10;

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        pm1_next    = pm1_reg;
        pm25_next   = pm25_reg;
        pm10_next   = pm10_reg;
        chk_hi_next = chk_hi_reg;
        hit         = 1'b0;
        if (step)
        begin
            priority if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == START_FIRST)
                begin
                    sum_next = WORD_W'(START_FIRST);
                    pos_next = POS_SECOND;
                end
            end
            else if (pos_reg == POS_SECOND)
            begin
                priority if (rx_byte == START_SECOND)
                begin
                    sum_next = sum_reg + WORD_W'(rx_byte);
                    pos_next = pos_reg + 1'b1;
                end
                else if (rx_byte == START_FIRST)
                begin
                    // A repeated start byte begins a fresh frame.
                    sum_next = WORD_W'(START_FIRST);
                    pos_next = POS_SECOND;
                end
                else
                begin
                    pos_next = POS_HUNT;
                end
            end
            else if (pos_reg < POS_CHK_HI)
            begin
                sum_next = sum_reg + WORD_W'(rx_byte);
                pos_next = pos_reg + 1'b1;
                if (pos_reg == POS_PM1_HI)  pm1_next  = {rx_byte, pm1_reg[BYTE_W-1:0]};
                if (pos_reg == POS_PM1_LO)  pm1_next  = {pm1_reg[WORD_W-1:BYTE_W], rx_byte};
                if (pos_reg == POS_PM25_HI) pm25_next = {rx_byte, pm25_reg[BYTE_W-1:0]};
                if (pos_reg == POS_PM25_LO) pm25_next = {pm25_reg[WORD_W-1:BYTE_W], rx_byte};
                if (pos_reg == POS_PM10_HI) pm10_next = {rx_byte, pm10_reg[BYTE_W-1:0]};
                if (pos_reg == POS_PM10_LO) pm10_next = {pm10_reg[WORD_W-1:BYTE_W], rx_byte};
            end
            else if (pos_reg == POS_CHK_HI)
            begin
                chk_hi_next = rx_byte;
                pos_next    = POS_CHK_LO;
            end
            else
            begin
                pos_next = POS_HUNT;
                hit      = ({chk_hi_reg, rx_byte} == sum_reg);
            end
        end
    end

    assign cat25 = grade(pm25_reg, PM25_LIMITS);
    assign cat10 = grade(pm10_reg, PM10_LIMITS);

    always_comb
    begin
        result.pm1_value      = pm1_reg;
        result.pm25_value     = pm25_reg;
        result.pm10_value     = pm10_reg;
        result.pm25_category  = cat25;
        result.pm10_category  = cat10;
        result.worst_category = (cat25 > cat10) ? cat25 : cat10;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        pm1_reg    <= pm1_next;
        pm25_reg   <= pm25_next;
        pm10_reg   <= pm10_next;
        chk_hi_reg <= chk_hi_next;
    end

    a_hit_at_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> step && pos_reg == POS_CHK_LO)
        else $error("frame result outside the last frame byte");

    a_hit_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> pos_reg == POS_HUNT)
        else $error("parser did not return to hunting after a frame");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(pos_reg))
        else $error("frame position moved without a byte");

endmodule

[rtl/core/particle_sensor_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Parses 32-byte particle sensor frames and reports checked concentrations.
// ----------------------------------------------------------------------------
// The block takes one serial byte per clock cycle on in_ch and needs no setup.
// Every byte passes an input register and is then consumed by the frame parser,
// whose position counter and 16-bit checksum adder take the byte as it leaves
// that register; a frame that checks out is written to the result register
// as its last byte moves on, and out_ch shows it from the result register.
// That last byte waits while the result register still holds an earlier frame.
// The throughput is one byte per cycle for as long as out_ch takes results;
// a waiting result stalls the input only when the input register is also full.
// Bytes are dropped until the start pair 0x42 0x4d is seen. Frames whose
// checksum word (bytes 30 and 31, high byte first) differs from the sum of
// bytes 0 to 29 give no request on out_ch.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser (
    input  logic          clk,
    input  logic          rst_n,
    pspf_byte_if.sink     in_ch,
    pspf_result_if.source out_ch
);
    import pspf_pkg::*;

    // Input register stage.
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // Result register stage.
    logic              out_valid_reg, out_valid_next;
    pspf_result_t      out_data_reg;

    logic              advance;
    logic              in_take;
    logic              hit;
    pspf_result_t      result;

    // The held byte moves into the parser whenever the result register is
    // free or is being emptied in this same cycle.
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    pspf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .hit     (hit),
        .result  (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            // A byte that ends no good frame still frees the result slot.
            out_valid_next = hit;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= in_ch.rx_byte;
        end
        if (advance && hit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pm1_value      = out_data_reg.pm1_value;
    assign out_ch.pm25_value     = out_data_reg.pm25_value;
    assign out_ch.pm10_value     = out_data_reg.pm10_value;
    assign out_ch.pm25_category  = out_data_reg.pm25_category;
    assign out_ch.pm10_category  = out_data_reg.pm10_category;
    assign out_ch.worst_category = out_data_reg.worst_category;

    // A held byte that cannot move on must stay in the input register.
    a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && byte_reg == $past(byte_reg))
        else $error("held input byte lost while the parser was stalled");

    // A pending result is never overwritten by the next parsed byte.
    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !advance)
        else $error("parser advanced over a result that was not taken");

    // The worst category is never below either of the two it is taken from.
    a_worst_category: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.worst_category >= out_data_reg.pm25_category &&
                          out_data_reg.worst_category >= out_data_reg.pm10_category)
        else $error("worst category below a component category");

endmodule
